// ----- src/ring_fifo_with_member_search_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef RING_FIFO_WITH_MEMBER_SEARCH_MACROS_SVH
`define RING_FIFO_WITH_MEMBER_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RFMS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RFMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rfms_pkg.sv -----
package rfms_pkg;

	localparam int OP_W    = 2;
	localparam int VALUE_W = 16;
	localparam int SLOTS_W = 5;
	localparam int OCC_W   = 4;

	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIN,
		ST_SEARCH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic push;
		logic pop;
		logic flush;
		logic search_start;
		logic search_step;
		logic res_load;
		logic res_word;
		logic res_found;
		logic res_refused;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic last;
		logic hit;
	} dp_stat_t;

endpackage

// ----- src/rfms_req_if.sv -----
interface rfms_req_if import rfms_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

// ----- src/rfms_rsp_if.sv -----
interface rfms_rsp_if import rfms_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] read_word;
	logic               found;
	logic               is_empty;
	logic               is_full;
	logic [OCC_W-1:0]   occupancy;
	logic               refused;

	modport source (
		output valid, output read_word, output found, output is_empty,
		output is_full, output occupancy, output refused, input ready
	);
	modport sink (
		input valid, input read_word, input found, input is_empty,
		input is_full, input occupancy, input refused, output ready
	);
endinterface

// ----- src/rfms_ram.sv -----
module rfms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/rfms_ctrl.sv -----
`include "ring_fifo_with_member_search_macros.svh"

module rfms_ctrl import rfms_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [OP_W-1:0] req_op,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  dp_stat_t        stat,
	output ctrl_cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   pop_ok_q, pop_ok_d;
	logic   refuse_q, refuse_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pop_ok_q    <= 1'b0;
			refuse_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			pop_ok_q <= pop_ok_d;
			refuse_q <= refuse_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		accept    = 1'b0;
		pop_ok_d  = pop_ok_q;
		refuse_d  = refuse_q;
		unique case (state_q)
			ST_IDLE: begin
				// take a request only if the result slot is free after this edge
				req_ready = !out_valid_q || rsp_ready;
				accept    = req_valid && req_ready;
				if (accept) begin
					pop_ok_d = 1'b0;
					refuse_d = 1'b0;
					state_d  = ST_FIN;
					unique case (op_t'(req_op))
						OP_PUSH: begin
							if (stat.full) begin
								refuse_d = 1'b1;
							end else begin
								cmd.push = 1'b1;
							end
						end
						OP_POP: begin
							if (stat.empty) begin
								refuse_d = 1'b1;
							end else begin
								cmd.pop  = 1'b1;
								pop_ok_d = 1'b1;
							end
						end
						OP_FLUSH: begin
							cmd.flush = 1'b1;
						end
						OP_SEARCH: begin
							if (!stat.empty) begin
								cmd.search_start = 1'b1;
								state_d          = ST_SEARCH;
							end
						end
					endcase
				end
			end
			ST_FIN: begin
				cmd.res_load    = 1'b1;
				cmd.res_word    = pop_ok_q;
				cmd.res_refused = refuse_q;
				state_d         = ST_IDLE;
			end
			ST_SEARCH: begin
				// one compare per cycle, read of the next slot already in flight
				if (stat.hit || stat.last) begin
					cmd.res_load  = 1'b1;
					cmd.res_found = stat.hit;
					state_d       = ST_IDLE;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	`RFMS_ASSERT_SAME(a_no_result_overwrite, clk, arst_n, cmd.res_load, !out_valid_q, "result overwritten before taken")
	`RFMS_ASSERT_NEXT(a_accept_frees_slot, clk, arst_n, accept, !out_valid_q, "result slot busy after accept")
	`RFMS_ASSERT_NEXT(a_search_walks, clk, arst_n, cmd.search_start, state_q == ST_SEARCH, "search start did not enter walk")

endmodule

// ----- src/rfms_datapath.sv -----
`include "ring_fifo_with_member_search_macros.svh"

module rfms_datapath import rfms_pkg::*; #(
	parameter int RING_DEPTH = 16,
	parameter int WORD_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [SLOTS_W-1:0] cfg_wr_data,
	input  logic [VALUE_W-1:0] value,
	input  ctrl_cmd_t          cmd,
	output dp_stat_t           stat,
	output logic [VALUE_W-1:0] read_word,
	output logic               found,
	output logic               is_empty,
	output logic               is_full,
	output logic [OCC_W-1:0]   occupancy,
	output logic               refused
);

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int SIZE_W = $clog2(RING_DEPTH + 1);
	localparam int NXT_W  = SIZE_W + 1;
	localparam int VB     = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;
	localparam int SIZE_RESET_I =
		(int'(SLOTS_RESET) > RING_DEPTH) ? RING_DEPTH : int'(SLOTS_RESET);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SIZE_RESET_I);

	logic [SIZE_W-1:0]    size_q, size_d;
	logic [PTR_W-1:0]     head_q, tail_q, ptr_q, left_q;
	logic [PTR_W-1:0]     adv_head, adv_tail, adv_ptr, raddr;
	logic [SIZE_W-1:0]    held_w;
	logic [WORD_BITS-1:0] word_in, key_q, rdata;

	logic [VALUE_W-1:0]   read_word_q;
	logic                 found_q, empty_q, full_q, refused_q;
	logic [OCC_W-1:0]     occ_q;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
	                                            input logic [SIZE_W-1:0] sz);
		logic [NXT_W-1:0] n;
		n = NXT_W'(p) + NXT_W'(1);
		return (n >= NXT_W'(sz)) ? '0 : PTR_W'(n);
	endfunction

	// ring size from the register, clamped to 2 .. RING_DEPTH
	always_comb begin
		if (cfg_wr_data < SLOTS_W'(2)) begin
			size_d = SIZE_W'(2);
		end else if (32'(cfg_wr_data) > RING_DEPTH) begin
			size_d = SIZE_W'(RING_DEPTH);
		end else begin
			size_d = SIZE_W'(cfg_wr_data);
		end
	end

	assign adv_head = advance(head_q, size_q);
	assign adv_tail = advance(tail_q, size_q);
	assign adv_ptr  = advance(ptr_q, size_q);
	assign raddr    = cmd.search_step ? adv_ptr : adv_head;
	assign word_in  = WORD_BITS'(value[VB-1:0]);

	always_comb begin
		if (tail_q >= head_q) begin
			held_w = SIZE_W'(tail_q) - SIZE_W'(head_q);
		end else begin
			held_w = SIZE_W'(tail_q) + size_q - SIZE_W'(head_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			head_q <= '0;
			tail_q <= '0;
			ptr_q  <= '0;
			left_q <= '0;
		end else if (cfg_wr_en) begin
			size_q <= size_d;
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (cmd.flush) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.push) begin
					tail_q <= adv_tail;
				end
				if (cmd.pop) begin
					head_q <= adv_head;
				end
			end
			if (cmd.search_start) begin
				ptr_q  <= adv_head;
				left_q <= PTR_W'(held_w);
			end else if (cmd.search_step) begin
				ptr_q  <= adv_ptr;
				left_q <= left_q - PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search_start) begin
			key_q <= word_in;
		end
		if (cmd.res_load) begin
			read_word_q <= cmd.res_word ? VALUE_W'(rdata[VB-1:0]) : '0;
			found_q     <= cmd.res_found;
			empty_q     <= (head_q == tail_q);
			full_q      <= (adv_tail == head_q);
			occ_q       <= OCC_W'(held_w);
			refused_q   <= cmd.res_refused;
		end
	end

	rfms_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (RING_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (adv_tail),
		.wdata (word_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (adv_tail == head_q);
	assign stat.last  = (left_q == PTR_W'(1));
	assign stat.hit   = (rdata == key_q);

	assign read_word = read_word_q;
	assign found     = found_q;
	assign is_empty  = empty_q;
	assign is_full   = full_q;
	assign occupancy = occ_q;
	assign refused   = refused_q;

	`RFMS_ASSERT_SAME(a_head_in_ring, clk, arst_n, 1'b1, NXT_W'(head_q) < NXT_W'(size_q), "head outside ring")
	`RFMS_ASSERT_SAME(a_tail_in_ring, clk, arst_n, 1'b1, NXT_W'(tail_q) < NXT_W'(size_q), "tail outside ring")
	`RFMS_ASSERT_SAME(a_step_has_more, clk, arst_n, cmd.search_step, left_q > PTR_W'(1), "search stepped past last entry")

endmodule

// ----- src/ring_fifo_with_member_search.sv -----
// Channel   Dir  Payload                                               Handshake
// req       in   op[1:0], value[15:0]                                  valid/ready
// rsp       out  read_word[15:0], found, is_empty, is_full,            valid/ready
//                occupancy[3:0], refused
// cfg       in   cfg_wr_data[4:0] (ring slots in use)                  cfg_wr_en
//
// Push, pop and flush pass ST_IDLE then ST_FIN; pop's word is the store's registered read.
// A search walks held entries oldest first; an empty ring skips the walk (not found);
// one store read and compare per cycle, and a hit ends the walk early.
// One request is in work at a time; the result register frees the input side as it drains.
// req.ready drops while a result waits and rsp.ready is low.
// arst_n clears pointers, ring size (16 slots) and the controller; store contents stay.
module ring_fifo_with_member_search import rfms_pkg::*; #(
	parameter int RING_DEPTH = 16,
	parameter int WORD_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [SLOTS_W-1:0] cfg_wr_data,
	rfms_req_if.sink           req,
	rfms_rsp_if.source         rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rfms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_op    (req.op),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rfms_datapath #(
		.RING_DEPTH (RING_DEPTH),
		.WORD_BITS  (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.value       (req.value),
		.cmd         (cmd),
		.stat        (stat),
		.read_word   (rsp.read_word),
		.found       (rsp.found),
		.is_empty    (rsp.is_empty),
		.is_full     (rsp.is_full),
		.occupancy   (rsp.occupancy),
		.refused     (rsp.refused)
	);

endmodule
